[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/bads_pkg.sv]
package bads_pkg;

   localparam int SYMBOL_WIDTH    = 8;
   localparam int PAIR_WIDTH      = 16;
   localparam int POSITION_WIDTH  = 16;
   localparam int DEPTH_WIDTH     = 5;
   localparam int ENABLE_WIDTH    = 4;
   localparam int REG_PAIRS       = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [SYMBOL_WIDTH-1:0]    symbol_type;
   typedef logic [PAIR_WIDTH-1:0]      pair_type;
   typedef logic [POSITION_WIDTH-1:0]  position_type;
   typedef logic [DEPTH_WIDTH-1:0]     depth_type;
   typedef logic [ENABLE_WIDTH-1:0]    enable_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam csr_index_type REG_SEPARATOR  = 3'd0;
   localparam csr_index_type REG_PAIR_ZERO  = 3'd1;
   localparam csr_index_type REG_PAIR_ONE   = 3'd2;
   localparam csr_index_type REG_PAIR_TWO   = 3'd3;
   localparam csr_index_type REG_PAIR_THREE = 3'd4;
   localparam csr_index_type REG_ENABLE     = 3'd5;

   localparam symbol_type CHAR_PAREN_OPEN   = 8'h28;
   localparam symbol_type CHAR_PAREN_CLOSE  = 8'h29;
   localparam symbol_type CHAR_SQUARE_OPEN  = 8'h5B;
   localparam symbol_type CHAR_SQUARE_CLOSE = 8'h5D;
   localparam symbol_type CHAR_CURLY_OPEN   = 8'h7B;
   localparam symbol_type CHAR_CURLY_CLOSE  = 8'h7D;
   localparam symbol_type CHAR_QUOTE        = 8'h22;
   localparam symbol_type CHAR_COMMA        = 8'h2C;

   localparam position_type POSITION_MAX = 16'hFFFF;

endpackage

[design/bads_ram.sv]
module bads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bracket_aware_separator_detector.sv]
// pipeline: input register, then result register, between a req transaction and the earliest
//   rsp transaction
// throughput: one transaction per cycle unless rsp_ready stalls, set by the top-of-stack
//   register and the stack ram prefetching the entry below the top each cycle
// reset: synchronous, active high; empties the stack, clears position and loads
//   the default separator, bracket pairs and enables
module bracket_aware_separator_detector #(
   parameter int STACK_DEPTH = 16,
   parameter int NUM_PAIRS   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bads_pkg::symbol_type    req_symbol,
   input  logic                    req_first,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_split,
   output bads_pkg::position_type  rsp_position,
   output bads_pkg::depth_type     rsp_depth,
   output logic                    rsp_overflow,
   input  logic                    csr_we,
   input  bads_pkg::csr_index_type csr_index,
   input  bads_pkg::csr_data_type  csr_wdata
);

   import bads_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PAIR_LIMIT = (NUM_PAIRS < REG_PAIRS) ? NUM_PAIRS : REG_PAIRS;

   // configuration
   symbol_type   separator_ff;
   pair_type     pair_ff [REG_PAIRS];
   enable_type   enable_ff;

   // input stage
   logic         in_valid_ff;
   symbol_type   in_symbol_ff;
   logic         in_first_ff;

   // scan state
   logic [CW-1:0] count_ff, count_in;
   position_type  index_ff, index_in;
   symbol_type    top_ff, top_in;

   // result stage
   logic          rsp_valid_ff;
   logic          rsp_split_ff;
   position_type  rsp_position_ff;
   depth_type     rsp_depth_ff;
   logic          rsp_overflow_ff;

   logic          advance, fire;
   logic [CW-1:0] base_count, step_count;
   position_type  base_index;
   logic          pop, opened, push, overflow, split;
   symbol_type    closer, below_data;
   logic [AW-1:0] rd_addr;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      base_count = in_first_ff ? '0 : count_ff;
      base_index = in_first_ff ? '0 : index_ff;
      pop        = (base_count != '0) && (in_symbol_ff == top_ff);

      opened = 1'b0;
      closer = '0;
      for (int i = PAIR_LIMIT - 1; i >= 0; i--) begin
         if (enable_ff[i] && (pair_ff[i][15:8] == in_symbol_ff)) begin
            opened = 1'b1;
            closer = pair_ff[i][7:0];
         end
      end

      push     = !pop && opened && (base_count < CW'(STACK_DEPTH));
      overflow = !pop && opened && !(base_count < CW'(STACK_DEPTH));
      split    = !pop && !opened && (base_count == '0) && (in_symbol_ff == separator_ff);

      priority if (pop) begin
         step_count = base_count - CW'(1);
         top_in     = below_data;
      end else if (push) begin
         step_count = base_count + CW'(1);
         top_in     = closer;
      end else begin
         step_count = base_count;
         top_in     = top_ff;
      end

      count_in = fire ? step_count : count_ff;
      index_in = (base_index != POSITION_MAX) ? base_index + 16'd1 : base_index;
      rd_addr  = AW'(count_in - CW'(2));
   end

   bads_ram #(
      .WIDTH(SYMBOL_WIDTH),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (fire && push),
      .wr_addr(AW'(base_count)),
      .wr_data(closer),
      .rd_addr(rd_addr),
      .rd_data(below_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= CHAR_COMMA;
         pair_ff[0]   <= {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE};
         pair_ff[1]   <= {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE};
         pair_ff[2]   <= {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE};
         pair_ff[3]   <= {CHAR_QUOTE, CHAR_QUOTE};
         enable_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SEPARATOR:  separator_ff <= csr_wdata[7:0];
            REG_PAIR_ZERO:  pair_ff[0]   <= csr_wdata;
            REG_PAIR_ONE:   pair_ff[1]   <= csr_wdata;
            REG_PAIR_TWO:   pair_ff[2]   <= csr_wdata;
            REG_PAIR_THREE: pair_ff[3]   <= csr_wdata;
            REG_ENABLE:     enable_ff    <= csr_wdata[ENABLE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         index_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            count_ff <= step_count;
            index_ff <= index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_symbol_ff <= req_symbol;
         in_first_ff  <= req_first;
      end
      if (fire) begin
         top_ff          <= top_in;
         rsp_split_ff    <= split;
         rsp_position_ff <= base_index;
         rsp_depth_ff    <= DEPTH_WIDTH'(step_count);
         rsp_overflow_ff <= overflow;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_split    = rsp_split_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_depth    = rsp_depth_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[design/bads_checker.sv]
`include "assert_macros.svh"

module bads_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_split,
   input bads_pkg::position_type rsp_position,
   input bads_pkg::depth_type    rsp_depth,
   input logic                   rsp_overflow
);

   import bads_pkg::*;

   logic        rsp_stall;
   logic        req_fire;
   logic [22:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_payload = {rsp_split, rsp_position, rsp_depth, rsp_overflow};

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // split only at depth zero
   `ASSERT_SAME(a_split_depth, clock, reset, rsp_valid && rsp_split, rsp_depth == '0)

   // a dropped opener never splits
   `ASSERT_SAME(a_overflow_no_split, clock, reset, rsp_valid && rsp_overflow, !rsp_split)

   // results come only after a req transaction has passed the input and result registers
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, !rsp_valid && !req_fire && !$past(req_fire), !rsp_valid)

endmodule

bind bracket_aware_separator_detector bads_checker u_bads_checker (.*);

[test/tb_bracket_aware_separator_detector.sv]
`timescale 1ns / 1ps

module tb_bracket_aware_separator_detector;
   import bads_pkg::*;

   localparam int STACK_DEPTH    = 16;
   localparam int NUM_PAIRS      = 4;
   localparam int ACTIVE_PAIRS   = (NUM_PAIRS < REG_PAIRS) ? NUM_PAIRS : REG_PAIRS;
   localparam int CLOCK_HALF     = 6;
   localparam int CLOCK_PERIOD   = 2 * CLOCK_HALF;
   localparam int RESET_CYCLES   = 5;
   localparam int LATENCY        = 2;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 800;
   localparam int DRAIN_LIMIT    = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   localparam csr_index_type REG_SPARE_LOW  = 3'd6;
   localparam csr_index_type REG_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic         split;
      position_type position;
      depth_type    depth;
      logic         overflow;
   } scan_result_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_ready;
   symbol_type    req_symbol   = '0;
   logic          req_first    = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready    = 1'b0;
   logic          rsp_split;
   position_type  rsp_position;
   depth_type     rsp_depth;
   logic          rsp_overflow;
   logic          csr_we       = 1'b0;
   csr_index_type csr_index    = '0;
   csr_data_type  csr_wdata    = '0;

   // predictor state
   symbol_type  sep_model = CHAR_COMMA;
   pair_type    pair_model [REG_PAIRS] = '{
      {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE},
      {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE},
      {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE},
      {CHAR_QUOTE, CHAR_QUOTE}};
   enable_type  enable_model = 4'hF;
   symbol_type  stack_mem [STACK_DEPTH];
   int unsigned stack_fill    = 0;
   int unsigned next_position = 0;

   scan_result_type expected_scans [$];

   bit steady_flow  = 1'b0;
   bit hold_request = 1'b0;
   int sent_count     = 0;
   int checked_count  = 0;
   int fail_count     = 0;
   int splits_seen    = 0;
   int overflows_seen = 0;
   int max_depth_seen = 0;
   int settings_count = 0;

   bracket_aware_separator_detector #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_PAIRS   (NUM_PAIRS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_symbol   (req_symbol),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_split    (rsp_split),
      .rsp_position (rsp_position),
      .rsp_depth    (rsp_depth),
      .rsp_overflow (rsp_overflow),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic scan_result_type scan_symbol(input symbol_type sym,
                                                   input logic start_flag);
      scan_result_type r;
      int pair_hit;
      r = '0;
      pair_hit = -1;
      if (start_flag) begin
         stack_fill = 0;
         next_position = 0;
      end
      r.position = next_position[15:0];
      if (next_position < 32'hFFFF) next_position++;
      if (stack_fill > 0 && sym == stack_mem[stack_fill - 1]) begin
         stack_fill--;
      end else begin
         for (int i = 0; i < ACTIVE_PAIRS; i++) begin
            if (pair_hit < 0 && enable_model[i] && pair_model[i][15:8] == sym) pair_hit = i;
         end
         if (pair_hit >= 0) begin
            if (stack_fill < STACK_DEPTH) begin
               stack_mem[stack_fill] = pair_model[pair_hit][7:0];
               stack_fill++;
            end else begin
               r.overflow = 1'b1;
            end
         end else if (stack_fill == 0 && sym == sep_model) begin
            r.split = 1'b1;
         end
      end
      r.depth = stack_fill[4:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // bias toward openers, the expected closer and the separator
   function automatic symbol_type pick_symbol(input int open_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < open_pct) return pair_model[$urandom_range(0, REG_PAIRS - 1)][15:8];
      roll = $urandom_range(0, 99);
      if (roll < 45 && stack_fill > 0) return stack_mem[stack_fill - 1];
      if (roll < 65) return sep_model;
      return symbol_type'($urandom_range(0, 255));
   endfunction

   function automatic symbol_type pick_code();
      case ($urandom_range(0, 11))
         0: return CHAR_PAREN_OPEN;
         1: return CHAR_PAREN_CLOSE;
         2: return CHAR_QUOTE;
         3: return CHAR_COMMA;
         4: return 8'h00;
         5: return 8'hFF;
         default: return symbol_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_symbol(input symbol_type sym, input logic start_flag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_first  <= start_flag;
      do @(posedge clock); while (!req_ready);
      expected_scans.insert(expected_scans.size(), scan_symbol(sym, start_flag));
      sent_count++;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_scans.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input csr_data_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_SEPARATOR:  sep_model = value[7:0];
         REG_PAIR_ZERO:  pair_model[0] = value;
         REG_PAIR_ONE:   pair_model[1] = value;
         REG_PAIR_TWO:   pair_model[2] = value;
         REG_PAIR_THREE: pair_model[3] = value;
         REG_ENABLE:     enable_model = value[3:0];
         default: ;
      endcase
   endtask

   task automatic load_setting(input symbol_type sep, input pair_type p0, input pair_type p1,
                               input pair_type p2, input pair_type p3, input enable_type en);
      wait_idle();
      write_csr(REG_SEPARATOR, {symbol_type'($urandom_range(0, 255)), sep});
      write_csr(REG_PAIR_ZERO, p0);
      write_csr(REG_PAIR_ONE, p1);
      write_csr(REG_PAIR_TWO, p2);
      write_csr(REG_PAIR_THREE, p3);
      write_csr(REG_ENABLE, {12'($urandom_range(0, 4095)), en});
      // unmapped indexes must not disturb anything
      write_csr(REG_SPARE_LOW, csr_data_type'($urandom_range(0, 65535)));
      write_csr(REG_SPARE_HIGH, csr_data_type'($urandom_range(0, 65535)));
      settings_count++;
   endtask

   task automatic send_text(input int length, input int open_pct, input bit start_new);
      for (int n = 0; n < length; n++) begin
         send_symbol(pick_symbol(open_pct), start_new && n == 0);
      end
   endtask

   task automatic run_texts(input int count);
      int base;
      base = sent_count;
      while (sent_count - base < count) begin
         steady_flow = ($urandom_range(0, 7) == 0);
         send_text($urandom_range(1, 40), ($urandom_range(0, 3) == 0) ? 70 : 35,
                   $urandom_range(0, 9) != 0);
      end
      steady_flow = 1'b0;
      wait_idle();
   endtask

   task automatic test_default_brackets();
      send_symbol(8'h00, 1'b1);
      send_symbol(CHAR_QUOTE, 1'b0);
      send_symbol(CHAR_COMMA, 1'b0);
      send_symbol(CHAR_PAREN_OPEN, 1'b0);
      send_symbol(CHAR_PAREN_CLOSE, 1'b0);
      send_symbol(CHAR_QUOTE, 1'b0);
      send_symbol(CHAR_SQUARE_OPEN, 1'b0);
      send_symbol(CHAR_CURLY_OPEN, 1'b0);
      send_symbol(CHAR_CURLY_CLOSE, 1'b0);
      send_symbol(CHAR_SQUARE_CLOSE, 1'b0);
      send_symbol(CHAR_COMMA, 1'b0);
      send_symbol(8'hFF, 1'b1);
      send_symbol(CHAR_COMMA, 1'b0);
      wait_idle();
   endtask

   task automatic test_stack_overflow();
      send_symbol(CHAR_PAREN_OPEN, 1'b1);
      repeat (STACK_DEPTH) send_symbol(CHAR_PAREN_OPEN, 1'b0);
      send_symbol(CHAR_PAREN_CLOSE, 1'b0);
      send_symbol(CHAR_COMMA, 1'b0);
      wait_idle();
   endtask

   // shared opener resolves to the lowest pair, separator loses to an opener
   task automatic test_opener_priority();
      load_setting(CHAR_CURLY_OPEN, {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE},
                   {CHAR_PAREN_OPEN, CHAR_SQUARE_CLOSE}, {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE},
                   {CHAR_QUOTE, CHAR_QUOTE}, 4'hF);
      send_symbol(CHAR_PAREN_OPEN, 1'b1);
      send_symbol(CHAR_PAREN_CLOSE, 1'b0);
      send_symbol(CHAR_CURLY_OPEN, 1'b0);
      send_symbol(CHAR_CURLY_CLOSE, 1'b0);
      wait_idle();
      write_csr(REG_ENABLE, {12'h000, 4'b1110});
      send_symbol(CHAR_PAREN_OPEN, 1'b1);
      send_symbol(CHAR_SQUARE_CLOSE, 1'b0);
      send_symbol(CHAR_COMMA, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_settings();
      int share;
      share = RANDOM_ITEMS / 8;
      load_setting(CHAR_COMMA, {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE},
                   {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE}, {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE},
                   {CHAR_QUOTE, CHAR_QUOTE}, 4'hF);
      run_texts(share);
      load_setting(8'h00, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 4'hF);
      run_texts(share);
      load_setting(8'hFF, {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE},
                   {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE}, {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE},
                   {CHAR_QUOTE, CHAR_QUOTE}, 4'h0);
      run_texts(share);
      load_setting(CHAR_SQUARE_OPEN, {CHAR_PAREN_OPEN, CHAR_PAREN_CLOSE},
                   {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE}, {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE},
                   {CHAR_QUOTE, CHAR_QUOTE}, 4'b0101);
      run_texts(share);
      repeat (4) begin
         load_setting(pick_code(), {pick_code(), pick_code()}, {pick_code(), pick_code()},
                      {pick_code(), pick_code()}, {pick_code(), pick_code()},
                      enable_type'($urandom_range(0, 15)));
         run_texts(share);
      end
   endtask

   task automatic test_backpressure();
      steady_flow = 1'b1;
      hold_request = 1'b1;
      send_text(40, 40, 1'b1);
      steady_flow = 1'b0;
      wait_idle();
   endtask

   initial begin : result_sink
      int stall_left;
      scan_result_type want;
      scan_result_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.split    = rsp_split;
            got.position = rsp_position;
            got.depth    = rsp_depth;
            got.overflow = rsp_overflow;
            checked_count++;
            if (got.split) splits_seen++;
            if (got.overflow) overflows_seen++;
            if (int'(got.depth) > max_depth_seen) max_depth_seen = int'(got.depth);
            if (expected_scans.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result transaction at %0t", $realtime);
            end else begin
               want = expected_scans.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  expected split %0b position %0d depth %0d overflow %0b",
                              want.split, want.position, want.depth, want.overflow);
                     $display("  actual   split %0b position %0d depth %0d overflow %0b",
                              got.split, got.position, got.depth, got.overflow);
                  end
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_brackets();
      test_stack_overflow();
      test_opener_priority();
      test_random_settings();
      test_backpressure();
      wait_idle();
      $display("%0d symbols sent, %0d results checked across %0d register settings",
               sent_count, checked_count, settings_count);
      $display("%0d split points, %0d dropped openers, deepest stack %0d",
               splits_seen, overflows_seen, max_depth_seen);
      if (expected_scans.size() != 0)
         $display("%0d expected results never arrived", expected_scans.size());
      if (fail_count == 0 && expected_scans.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/bads_pkg.sv
design/bads_ram.sv
design/bracket_aware_separator_detector.sv
design/bads_checker.sv
test/tb_bracket_aware_separator_detector.sv
